// ----- rtl/core/pairwise_euclidean_distance_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the distance engine.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_EUCLIDEAN_DISTANCE_MACROS_SVH
`define PAIRWISE_EUCLIDEAN_DISTANCE_MACROS_SVH

// same-cycle implication
`define PED_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ped: same-cycle property violated");

// next-cycle implication
`define PED_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ped: next-cycle property violated");

`endif

// ----- rtl/core/ped_pkg.sv -----
// ----------------------------------------------------------------------------
// ped_pkg
// Widths, codes and defaults for the pairwise distance engine.
// ----------------------------------------------------------------------------
package ped_pkg;

  localparam int unsigned MAX_REFS_DEF = 64;
  localparam int unsigned MAX_DIM_DEF  = 256;

  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned DIST_W    = 43;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned VI_W      = 6;
  localparam int unsigned EI_W      = 8;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_QUERY = 2'd1;
  localparam mode_t MODE_SELF  = 2'd2;

  localparam cfg_idx_t CFG_DIMENSION = 3'd0;
  localparam cfg_idx_t CFG_REF_COUNT = 3'd1;
  localparam cfg_idx_t CFG_USE_QNORM = 3'd2;
  localparam cfg_idx_t CFG_USE_RNORM = 3'd3;
  localparam cfg_idx_t CFG_SQUARED   = 3'd4;

endpackage

// ----- rtl/core/ped_in_if.sv -----
// ----------------------------------------------------------------------------
// ped_in_if
// Input channel: one vector component or one self query per beat.
// ----------------------------------------------------------------------------
interface ped_in_if import ped_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [ELEM_W-1:0] value;
  logic [VI_W-1:0]         vector_index;
  logic [EI_W-1:0]         element_index;

  modport source (output valid, mode, value, vector_index, element_index, input ready);
  modport sink   (input valid, mode, value, vector_index, element_index, output ready);
endinterface

// ----- rtl/core/ped_out_if.sv -----
// ----------------------------------------------------------------------------
// ped_out_if
// Output channel: one distance per beat.
// ----------------------------------------------------------------------------
interface ped_out_if import ped_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] distance;
  logic [SLOT_W-1:0]        reference_slot;
  logic                     last;

  modport source (output valid, distance, reference_slot, last, input ready);
  modport sink   (input valid, distance, reference_slot, last, output ready);
endinterface

// ----- rtl/core/ped_ram.sv -----
// ----------------------------------------------------------------------------
// ped_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ped_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ped_isqrt.sv -----
// ----------------------------------------------------------------------------
// ped_isqrt
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ped_isqrt #(
  parameter int unsigned W = 43
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [W-1:0]         radicand_i,
  output logic                 done_o,
  output logic [(W+1)/2-1:0]   root_o
);

  localparam int unsigned RW = (W + 1) / 2;

  logic         busy_q;
  logic [W-1:0] n_q, res_q, bit_q;
  logic [W-1:0] trial;
  logic         fits;

  assign trial = res_q + bit_q;
  assign fits  = n_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= radicand_i;
      res_q <= '0;
      bit_q <= W'(1) << (2 * (RW - 1));
    end else if (busy_q && bit_q != '0) begin
      if (fits) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = busy_q && (bit_q == '0);
  assign root_o = RW'(res_q);

endmodule

// ----- rtl/core/pairwise_euclidean_distance.sv -----
// ----------------------------------------------------------------------------
// pairwise_euclidean_distance
// Reference store, query accumulation and per-reference distance sequencer.
//
//   channel  dir  beat
//   in_i     in   load component / query component / self query
//   out_o    out  distance, reference slot, last flag
//   cfg      in   register write, no handshake
//
// Load beats write the store directly. Each query component uses the shared
// multiplier; the final one then yields a distance per reference, through the
// square root unit unless squared output is set. A self query first forms its
// own norm, then per reference the reference norm and the cross product.
// Reset clears control state only; no clearing pass. Ready stays low while
// an item is in work; a result holds in the output register until taken.
// ----------------------------------------------------------------------------
`include "pairwise_euclidean_distance_macros.svh"

module pairwise_euclidean_distance import ped_pkg::*; #(
  parameter int unsigned MAX_REFERENCES = MAX_REFS_DEF,
  parameter int unsigned MAX_DIMENSION  = MAX_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  ped_in_if.sink               in_i,
  ped_out_if.source            out_o
);

  localparam int unsigned DEPTH = MAX_REFERENCES * MAX_DIMENSION;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int unsigned PAW   = SW;
  localparam int unsigned DW    = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CW    = $clog2(MAX_REFERENCES + 1);
  localparam int unsigned PW    = 2 * ELEM_W;
  localparam int unsigned RTW   = (DIST_W + 1) / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_QSQ, S_QNORM, S_QMUL, S_QACC, S_NEXT, S_DRA, S_DRB,
    S_DMUL, S_DACC, S_DDONE, S_PD, S_SUM, S_SQRT, S_OUT
  } state_e;

  typedef enum logic [1:0] {P_NQ, P_NR, P_X} phase_e;

  state_e state_q;
  phase_e phase_q;

  logic [CFG_W-1:0] dim_q;
  logic [6:0]       rc_q;
  logic             uq_q, ur_q, sq_q;

  logic [DW-1:0] dim_eff;
  logic [CW-1:0] cnt_eff;
  logic [SW-1:0] last_slot;

  logic                     self_q, emit_q;
  logic signed [ELEM_W-1:0] val_q, a_q;
  logic [EI_W-1:0]          ei_q;
  logic [SW-1:0]            vi_q, r_q, r_nx;
  logic [DW-1:0]            e_q;
  logic signed [PW-1:0]     prod_q, prod_d;
  logic signed [ELEM_W-1:0] mul_a, mul_b;
  logic [ACC_W-1:0]         prod_x;
  logic [ACC_W-1:0]         acc_q, qn_q, nq_q, nr_q, x_q;
  logic [MAX_REFERENCES-1:0] pd_vld_q;

  logic                     out_vld_q;
  logic signed [DIST_W-1:0] dist_q;
  logic                     out_last;

  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [ELEM_W-1:0] st_rdata;
  logic [SW-1:0] slot_a, slot_b;

  logic              pd_we, pd_re;
  logic [PAW-1:0]    pd_raddr;
  logic [ACC_W-1:0]  pd_rdata, pd_eff, pd_sum;

  logic                     in_rdy, in_acc;
  logic                     vi_ok, ei_load_ok, ei_query_ok;
  logic signed [DIST_W-1:0] t1, t2, t3, d_sum;
  logic                     d_pos;
  logic                     sqrt_start, sqrt_done;
  logic [RTW-1:0]           sqrt_root;

  function automatic logic signed [DIST_W-1:0] sx(input logic [ACC_W-1:0] a);
    sx = {{(DIST_W-ACC_W){a[ACC_W-1]}}, a};
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= CFG_W'(1);
      rc_q  <= 7'd1;
      uq_q  <= 1'b1;
      ur_q  <= 1'b1;
      sq_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIMENSION: dim_q <= cfg_wdata_i;
        CFG_REF_COUNT: rc_q  <= cfg_wdata_i[6:0];
        CFG_USE_QNORM: uq_q  <= cfg_wdata_i[0];
        CFG_USE_RNORM: ur_q  <= cfg_wdata_i[0];
        CFG_SQUARED:   sq_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_q == '0) begin
      dim_eff = DW'(1);
    end else if (32'(dim_q) > MAX_DIMENSION) begin
      dim_eff = DW'(MAX_DIMENSION);
    end else begin
      dim_eff = DW'(dim_q);
    end
    if (rc_q == '0) begin
      cnt_eff = CW'(1);
    end else if (32'(rc_q) > MAX_REFERENCES) begin
      cnt_eff = CW'(MAX_REFERENCES);
    end else begin
      cnt_eff = CW'(rc_q);
    end
  end

  assign last_slot = SW'(cnt_eff - CW'(1));
  assign r_nx      = r_q + SW'(1);

  assign in_rdy      = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_rdy;
  assign vi_ok       = 32'(in_i.vector_index) < MAX_REFERENCES;
  assign ei_load_ok  = 32'(in_i.element_index) < MAX_DIMENSION;
  assign ei_query_ok = 32'(in_i.element_index) < 32'(dim_eff);

  // shared multiplier
  always_comb begin
    mul_a = val_q;
    mul_b = val_q;
    case (state_q)
      S_QMUL: mul_b = st_rdata;
      S_DMUL: begin
        mul_a = a_q;
        mul_b = st_rdata;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign prod_x = {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // reference store
  assign st_we    = in_acc && (in_i.mode == MODE_LOAD) && vi_ok && ei_load_ok;
  assign st_waddr = AW'(in_i.vector_index) * AW'(MAX_DIMENSION) + AW'(in_i.element_index);
  assign slot_a   = (phase_q == P_NR) ? r_q : vi_q;
  assign slot_b   = (phase_q == P_NQ) ? vi_q : r_q;

  always_comb begin
    st_re    = 1'b0;
    st_raddr = '0;
    pd_re    = 1'b0;
    pd_raddr = '0;
    case (state_q)
      S_QNORM: begin
        st_re    = 1'b1;
        st_raddr = AW'(ei_q);
        pd_re    = 1'b1;
      end
      S_QACC: begin
        st_re    = (r_q != last_slot);
        st_raddr = AW'(r_nx) * AW'(MAX_DIMENSION) + AW'(ei_q);
        pd_re    = (r_q != last_slot);
        pd_raddr = r_nx;
      end
      S_DRA: begin
        st_re    = 1'b1;
        st_raddr = AW'(slot_a) * AW'(MAX_DIMENSION) + AW'(e_q);
      end
      S_DRB: begin
        st_re    = 1'b1;
        st_raddr = AW'(slot_b) * AW'(MAX_DIMENSION) + AW'(e_q);
      end
      S_PD: begin
        pd_re    = 1'b1;
        pd_raddr = r_q;
      end
      default: ;
    endcase
  end

  ped_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (in_i.value),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // partial dot products
  assign pd_eff = pd_vld_q[r_q] ? pd_rdata : '0;
  assign pd_sum = pd_eff + prod_x;
  assign pd_we  = (state_q == S_QACC);

  ped_ram #(.WIDTH(ACC_W), .DEPTH(MAX_REFERENCES)) u_dots (
    .clk_i   (clk_i),
    .we_i    (pd_we),
    .waddr_i (r_q),
    .wdata_i (pd_sum),
    .re_i    (pd_re),
    .raddr_i (pd_raddr),
    .rdata_o (pd_rdata)
  );

  // distance combine
  always_comb begin
    if (self_q) begin
      t1 = uq_q ? sx(nq_q) : '0;
      t2 = uq_q ? sx(nr_q) : '0;
      t3 = sx(x_q);
    end else begin
      t1 = uq_q ? sx(qn_q) : '0;
      t2 = ur_q ? sx(nr_q) : '0;
      t3 = sx(pd_eff);
    end
    d_sum = t1 + t2 - (t3 <<< 1);
  end

  assign d_pos      = !d_sum[DIST_W-1] && (d_sum != '0);
  assign sqrt_start = (state_q == S_SUM) && !sq_q && d_pos;

  ped_isqrt #(.W(DIST_W)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (d_sum),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= P_NQ;
      self_q    <= 1'b0;
      emit_q    <= 1'b0;
      val_q     <= '0;
      a_q       <= '0;
      ei_q      <= '0;
      vi_q      <= '0;
      r_q       <= '0;
      e_q       <= '0;
      acc_q     <= '0;
      qn_q      <= '0;
      nq_q      <= '0;
      nr_q      <= '0;
      x_q       <= '0;
      pd_vld_q  <= '0;
      out_vld_q <= 1'b0;
      dist_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_i.mode)
              MODE_QUERY: begin
                if (ei_query_ok) begin
                  val_q   <= in_i.value;
                  ei_q    <= in_i.element_index;
                  emit_q  <= (DW'(in_i.element_index) == dim_eff - DW'(1));
                  self_q  <= 1'b0;
                  state_q <= S_QSQ;
                end
              end
              MODE_SELF: begin
                if (vi_ok) begin
                  vi_q    <= SW'(in_i.vector_index);
                  self_q  <= 1'b1;
                  phase_q <= P_NQ;
                  e_q     <= '0;
                  acc_q   <= '0;
                  state_q <= S_DRA;
                end
              end
              default: ;
            endcase
          end
        end
        S_QSQ: state_q <= S_QNORM;
        S_QNORM: begin
          qn_q    <= qn_q + prod_x;
          r_q     <= '0;
          state_q <= S_QMUL;
        end
        S_QMUL: state_q <= S_QACC;
        S_QACC: begin
          pd_vld_q[r_q] <= 1'b1;
          if (r_q == last_slot) begin
            r_q     <= '0;
            state_q <= emit_q ? S_NEXT : S_IDLE;
          end else begin
            r_q     <= r_nx;
            state_q <= S_QMUL;
          end
        end
        S_NEXT: begin
          if (self_q && (r_q == vi_q)) begin
            dist_q    <= '0;
            out_vld_q <= 1'b1;
            state_q   <= S_OUT;
          end else begin
            phase_q <= P_NR;
            e_q     <= '0;
            acc_q   <= '0;
            state_q <= S_DRA;
          end
        end
        S_DRA: state_q <= S_DRB;
        S_DRB: begin
          a_q     <= st_rdata;
          state_q <= S_DMUL;
        end
        S_DMUL: state_q <= S_DACC;
        S_DACC: begin
          acc_q <= acc_q + prod_x;
          if (e_q == dim_eff - DW'(1)) begin
            state_q <= S_DDONE;
          end else begin
            e_q     <= e_q + DW'(1);
            state_q <= S_DRA;
          end
        end
        S_DDONE: begin
          unique case (phase_q)
            P_NQ: begin
              nq_q    <= acc_q;
              r_q     <= '0;
              state_q <= S_NEXT;
            end
            P_NR: begin
              nr_q <= acc_q;
              if (self_q) begin
                phase_q <= P_X;
                e_q     <= '0;
                acc_q   <= '0;
                state_q <= S_DRA;
              end else begin
                state_q <= S_PD;
              end
            end
            P_X: begin
              x_q     <= acc_q;
              state_q <= S_SUM;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_PD: state_q <= S_SUM;
        S_SUM: begin
          if (sq_q) begin
            dist_q    <= d_sum;
            out_vld_q <= 1'b1;
            state_q   <= S_OUT;
          end else if (!d_pos) begin
            dist_q    <= '0;
            out_vld_q <= 1'b1;
            state_q   <= S_OUT;
          end else begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            dist_q    <= DIST_W'(sqrt_root);
            out_vld_q <= 1'b1;
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            out_vld_q <= 1'b0;
            if (r_q == last_slot) begin
              if (!self_q) begin
                pd_vld_q <= '0;
                qn_q     <= '0;
              end
              state_q <= S_IDLE;
            end else begin
              r_q     <= r_nx;
              state_q <= S_NEXT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_last = (r_q == last_slot);

  assign in_i.ready           = in_rdy;
  assign out_o.valid          = out_vld_q;
  assign out_o.distance       = dist_q;
  assign out_o.reference_slot = SLOT_W'(r_q);
  assign out_o.last           = out_last;

  `PED_ASSERT_IMP(a_no_accept_while_out, out_vld_q, !in_rdy)
  `PED_ASSERT_IMP(a_root_nonneg, out_vld_q && !sq_q, !dist_q[DIST_W-1])
  `PED_ASSERT_NXT(a_last_frees_input, out_vld_q && out_o.ready && out_last, in_rdy)

endmodule
